@@ rtl/hbws_pkg.sv @@
// Heartbeat watchdog supervisor package: cause codes, register indexes,
// reset values and the structs passed between the supervisor modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbws_pkg;

    localparam int unsigned BEAT_W     = 32;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned LIMIT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] MISS_MAX          = 8'hFF;
    localparam logic [LIMIT_W-1:0] RESET_MISS_LIMIT  = 8'd3;
    localparam logic [TICK_W-1:0]  RESET_GRACE_TICKS = 32'd3000;

    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS = 8'd1;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_SENSOR  = 2'd1,
        CAUSE_PROCESS = 2'd2,
        CAUSE_REPORT  = 2'd3
    } cause_t;

    typedef struct packed {
        logic sensor;
        logic process;
        logic report;
    } miss_hit_t;

    typedef struct packed {
        logic   feed;
        logic   fault;
        cause_t cause;
    } check_result_t;

endpackage

`default_nettype wire

@@ rtl/hbws_miss.sv @@
// One heartbeat lane: previous sample and saturating miss counter.
// Depends on hbws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbws_miss (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire logic [hbws_pkg::BEAT_W-1:0]  beat,
    input  wire logic [hbws_pkg::LIMIT_W-1:0] miss_limit,
    output logic                              hit
);

    logic [hbws_pkg::BEAT_W-1:0]  last_reg;
    logic [hbws_pkg::LIMIT_W-1:0] count_reg;
    logic [hbws_pkg::LIMIT_W-1:0] count_next;

    always_comb begin
        if (beat == last_reg) begin
            if (count_reg == hbws_pkg::MISS_MAX) begin
                count_next = count_reg;
            end else begin
                count_next = count_reg + 8'd1;
            end
        end else begin
            count_next = '0;
        end
        hit = (count_next >= miss_limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            count_reg <= '0;
        end else if (load) begin
            last_reg  <= beat;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hbws_fault.sv @@
// Fault latch, fault tick and cause, plus the feed decision with grace period.
// Depends on hbws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbws_fault (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire hbws_pkg::miss_hit_t         hits,
    input  wire logic [hbws_pkg::TICK_W-1:0] now_tick,
    input  wire logic [hbws_pkg::TICK_W-1:0] grace_ticks,
    output hbws_pkg::check_result_t          result
);

    logic                        fault_reg;
    logic                        fault_next;
    logic [hbws_pkg::TICK_W-1:0] fault_tick_reg;
    logic [hbws_pkg::TICK_W-1:0] elapsed;
    hbws_pkg::cause_t            cause_reg;
    hbws_pkg::cause_t            cause_next;
    logic                        any_hit;

    always_comb begin
        any_hit    = hits.sensor | hits.process | hits.report;
        fault_next = fault_reg | any_hit;
        cause_next = cause_reg;
        if (!fault_reg) begin
            if (hits.sensor) begin
                cause_next = hbws_pkg::CAUSE_SENSOR;
            end else if (hits.process) begin
                cause_next = hbws_pkg::CAUSE_PROCESS;
            end else if (hits.report) begin
                cause_next = hbws_pkg::CAUSE_REPORT;
            end
        end
        elapsed = now_tick - fault_tick_reg;
        if (!fault_next) begin
            result.feed = 1'b1;
        end else if (!fault_reg) begin
            result.feed = (grace_ticks != '0);
        end else begin
            result.feed = (elapsed < grace_ticks);
        end
        result.fault = fault_next;
        result.cause = cause_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg      <= 1'b0;
            fault_tick_reg <= '0;
            cause_reg      <= hbws_pkg::CAUSE_NONE;
        end else if (load) begin
            fault_reg <= fault_next;
            cause_reg <= cause_next;
            if (!fault_reg && any_hit) begin
                fault_tick_reg <= now_tick;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/heartbeat_watchdog_supervisor.sv @@
// Heartbeat watchdog supervisor top level: input register, three miss lanes,
// fault/feed logic and result register. Depends on hbws_pkg, hbws_miss, hbws_fault.
// A check beat passes the input register, then the result register, to the m_ channel.
// Throughput: one check per cycle unless m_ready stalls the result register; the
// single-pass compare/count logic between the input and result registers sets this.
// Reset: aresetn clears all lane history, miss counts, the fault latch and both
// pipeline valids, and restores miss_limit to 3 and grace_ticks to 3000.
`timescale 1ns / 1ps
`default_nettype none

module heartbeat_watchdog_supervisor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [hbws_pkg::BEAT_W-1:0]     s_sensor_beat,
    input  wire logic [hbws_pkg::BEAT_W-1:0]     s_process_beat,
    input  wire logic [hbws_pkg::BEAT_W-1:0]     s_report_beat,
    input  wire logic [hbws_pkg::TICK_W-1:0]     s_now_tick,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_feed,
    output logic                                 m_fault,
    output logic [1:0]                           m_fault_cause,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hbws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hbws_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [hbws_pkg::LIMIT_W-1:0] miss_limit_reg;
    logic [hbws_pkg::TICK_W-1:0]  grace_ticks_reg;

    logic                         in_valid_reg;
    logic [hbws_pkg::BEAT_W-1:0]  sensor_reg;
    logic [hbws_pkg::BEAT_W-1:0]  process_reg;
    logic [hbws_pkg::BEAT_W-1:0]  report_reg;
    logic [hbws_pkg::TICK_W-1:0]  tick_reg;

    logic                         out_valid_reg;
    hbws_pkg::check_result_t      out_reg;
    hbws_pkg::check_result_t      result;
    hbws_pkg::miss_hit_t          hits;

    logic out_open;
    logic advance;

    assign out_open  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_open;
    assign s_ready   = !in_valid_reg || out_open;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_limit_reg  <= hbws_pkg::RESET_MISS_LIMIT;
            grace_ticks_reg <= hbws_pkg::RESET_GRACE_TICKS;
        end else if (cfg_valid) begin
            if (cfg_index == hbws_pkg::REG_MISS_LIMIT) begin
                miss_limit_reg <= cfg_data[hbws_pkg::LIMIT_W-1:0];
            end else if (cfg_index == hbws_pkg::REG_GRACE_TICKS) begin
                grace_ticks_reg <= cfg_data[hbws_pkg::TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sensor_reg  <= s_sensor_beat;
            process_reg <= s_process_beat;
            report_reg  <= s_report_beat;
            tick_reg    <= s_now_tick;
        end
    end

    hbws_miss u_miss_sensor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .beat       (sensor_reg),
        .miss_limit (miss_limit_reg),
        .hit        (hits.sensor)
    );

    hbws_miss u_miss_process (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .beat       (process_reg),
        .miss_limit (miss_limit_reg),
        .hit        (hits.process)
    );

    hbws_miss u_miss_report (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .beat       (report_reg),
        .miss_limit (miss_limit_reg),
        .hit        (hits.report)
    );

    hbws_fault u_fault (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .hits        (hits),
        .now_tick    (tick_reg),
        .grace_ticks (grace_ticks_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_open) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_feed        = out_reg.feed;
    assign m_fault       = out_reg.fault;
    assign m_fault_cause = out_reg.cause;

endmodule

`default_nettype wire

@@ rtl/hbws_checker.sv @@
// Port-level checker for the heartbeat watchdog supervisor, bound to the top level.
// Depends on hbws_pkg and heartbeat_watchdog_supervisor.
`timescale 1ns / 1ps
`default_nettype none

module hbws_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_feed,
    input wire logic       m_fault,
    input wire logic [1:0] m_fault_cause
);

    logic       seen_fault_reg;
    logic [1:0] seen_cause_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_fault_reg <= 1'b0;
            seen_cause_reg <= hbws_pkg::CAUSE_NONE;
        end else if (m_valid && m_ready && m_fault && !seen_fault_reg) begin
            seen_fault_reg <= 1'b1;
            seen_cause_reg <= m_fault_cause;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_feed) && $stable(m_fault)
            && $stable(m_fault_cause))
        else $error("result beat changed while stalled");

    a_healthy_feeds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fault |-> m_feed && m_fault_cause == hbws_pkg::CAUSE_NONE)
        else $error("healthy beat without feed or with a cause");

    a_fault_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault |-> m_fault_cause != hbws_pkg::CAUSE_NONE)
        else $error("fault beat without a cause");

    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && seen_fault_reg |-> m_fault && m_fault_cause == seen_cause_reg)
        else $error("latched fault or cause changed");

endmodule

bind heartbeat_watchdog_supervisor hbws_checker u_hbws_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_feed        (m_feed),
    .m_fault       (m_fault),
    .m_fault_cause (m_fault_cause)
);

`default_nettype wire

@@ tb/heartbeat_watchdog_supervisor_test.sv @@
// Self-checking testbench for heartbeat_watchdog_supervisor: random check beats with
// random source gaps and sink stalls, predicted by an in-bench scoreboard class.
// Depends on hbws_pkg and the heartbeat_watchdog_supervisor RTL.
`timescale 1ns / 1ps

module heartbeat_watchdog_supervisor_test;

    localparam logic [hbws_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [hbws_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hFF;
    localparam int LANES = 3;

    typedef logic [hbws_pkg::LIMIT_W-1:0] limit_t;

    typedef struct packed {
        logic [hbws_pkg::BEAT_W-1:0] sensor;
        logic [hbws_pkg::BEAT_W-1:0] process;
        logic [hbws_pkg::BEAT_W-1:0] report;
        logic [hbws_pkg::TICK_W-1:0] tick;
    } check_beat_t;

    class health_board;
        logic [hbws_pkg::BEAT_W-1:0]  last_seen[LANES];
        logic [hbws_pkg::LIMIT_W-1:0] misses[LANES];
        logic [hbws_pkg::LIMIT_W-1:0] limit;
        logic [hbws_pkg::TICK_W-1:0]  grace;
        logic                         latched;
        logic [hbws_pkg::TICK_W-1:0]  latch_tick;
        hbws_pkg::cause_t             cause;
        hbws_pkg::check_result_t      verdicts_due[$];
        int                           errors;

        function new();
            for (int k = 0; k < LANES; k++) begin
                last_seen[k] = '0;
                misses[k] = '0;
            end
            limit = hbws_pkg::RESET_MISS_LIMIT;
            grace = hbws_pkg::RESET_GRACE_TICKS;
            latched = 1'b0;
            latch_tick = '0;
            cause = hbws_pkg::CAUSE_NONE;
            errors = 0;
        endfunction

        function void write_reg(logic [hbws_pkg::CFG_IDX_W-1:0] idx,
                                logic [hbws_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                hbws_pkg::REG_MISS_LIMIT: begin
                    limit = data[hbws_pkg::LIMIT_W-1:0];
                end
                hbws_pkg::REG_GRACE_TICKS: begin
                    grace = data;
                end
                default: begin
                end
            endcase
        endfunction

        function hbws_pkg::cause_t lane_cause(int k);
            case (k)
                0: return hbws_pkg::CAUSE_SENSOR;
                1: return hbws_pkg::CAUSE_PROCESS;
                default: return hbws_pkg::CAUSE_REPORT;
            endcase
        endfunction

        function void note_check(check_beat_t c);
            logic [hbws_pkg::BEAT_W-1:0] beat[LANES];
            logic [hbws_pkg::TICK_W-1:0] elapsed;
            hbws_pkg::check_result_t     v;
            beat[0] = c.sensor;
            beat[1] = c.process;
            beat[2] = c.report;
            for (int k = 0; k < LANES; k++) begin
                if (beat[k] == last_seen[k]) begin
                    if (misses[k] != hbws_pkg::MISS_MAX)
                        misses[k] = misses[k] + 8'd1;
                end else begin
                    misses[k] = '0;
                end
                last_seen[k] = beat[k];
            end
            for (int k = 0; k < LANES; k++) begin
                if (!latched && misses[k] >= limit) begin
                    latched = 1'b1;
                    latch_tick = c.tick;
                    cause = lane_cause(k);
                end
            end
            elapsed = c.tick - latch_tick;
            v.feed = !latched || (elapsed < grace);
            v.fault = latched;
            v.cause = cause;
            verdicts_due.push_back(v);
        endfunction

        function void compare_verdict(logic feed, logic fault, logic [1:0] cause_bits);
            hbws_pkg::check_result_t want;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: feed %0b fault %0b cause %0d",
                         $time, feed, fault, cause_bits);
                return;
            end
            want = verdicts_due.pop_front();
            if (feed !== want.feed) begin
                errors++;
                $display("%0t: feed expected %0b actual %0b", $time, want.feed, feed);
            end
            if (fault !== want.fault) begin
                errors++;
                $display("%0t: fault expected %0b actual %0b", $time, want.fault, fault);
            end
            if (cause_bits !== want.cause) begin
                errors++;
                $display("%0t: fault_cause expected %0d actual %0d", $time, want.cause,
                         cause_bits);
            end
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [hbws_pkg::BEAT_W-1:0]         s_sensor_beat;
    logic [hbws_pkg::BEAT_W-1:0]         s_process_beat;
    logic [hbws_pkg::BEAT_W-1:0]         s_report_beat;
    logic [hbws_pkg::TICK_W-1:0]         s_now_tick;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_feed;
    logic                                m_fault;
    logic [1:0]                          m_fault_cause;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [hbws_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [hbws_pkg::CFG_DATA_W-1:0]     cfg_data;

    logic                                calm;
    logic [hbws_pkg::TICK_W-1:0]         tick_now;
    health_board                         board;

    heartbeat_watchdog_supervisor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_beat  (s_sensor_beat),
        .s_process_beat (s_process_beat),
        .s_report_beat  (s_report_beat),
        .s_now_tick     (s_now_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_feed         (m_feed),
        .m_fault        (m_fault),
        .m_fault_cause  (m_fault_cause),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned pause_len();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // guard: never let a repeat reach the miss limit
    function automatic logic [hbws_pkg::BEAT_W-1:0] pick_beat(int k, int unsigned hold_odds,
                                                              bit guard);
        logic [hbws_pkg::BEAT_W-1:0] prev;
        logic [hbws_pkg::BEAT_W-1:0] v;
        prev = board.last_seen[k];
        if ($urandom_range(0, 15) < hold_odds) begin
            v = prev;
        end else begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = '1;
                2: v = prev + 32'd1;
                3: v = prev - 32'd1;
                default: v = $urandom;
            endcase
        end
        if (guard && v == prev && int'(board.misses[k]) + 1 >= int'(board.limit))
            v = prev + 32'd1;
        return v;
    endfunction

    function automatic logic [hbws_pkg::TICK_W-1:0] advance_tick();
        if ($urandom_range(0, 15) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(1, 1000);
        return tick_now;
    endfunction

    function automatic logic [hbws_pkg::TICK_W-1:0] tick_after_fault();
        logic [hbws_pkg::TICK_W-1:0] delta;
        case ($urandom_range(0, 6))
            0: delta = '0;
            1: delta = board.grace - 32'd1;
            2: delta = board.grace;
            3: delta = board.grace + 32'd1;
            4: delta = '1;
            5: delta = $urandom_range(0, 4000);
            default: delta = $urandom;
        endcase
        return board.latch_tick + delta;
    endfunction

    task automatic push_check(check_beat_t c);
        int unsigned gap;
        gap = pause_len();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_sensor_beat = c.sensor;
        s_process_beat = c.process;
        s_report_beat = c.report;
        s_now_tick = c.tick;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_check(c);
        @(negedge aclk);
    endtask

    task automatic write_reg_port(logic [hbws_pkg::CFG_IDX_W-1:0] idx,
                                  logic [hbws_pkg::CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (board.verdicts_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [hbws_pkg::CFG_DATA_W-1:0] limit_word(limit_t lim);
        logic [hbws_pkg::CFG_DATA_W-1:0] w;
        w = $urandom;
        w[hbws_pkg::LIMIT_W-1:0] = lim;
        return w;
    endfunction

    function automatic logic [hbws_pkg::TICK_W-1:0] pick_grace();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1, 2000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned mode;
        int unsigned hold;
        limit_t lim;
        logic [LANES-1:0] stuck;
        check_beat_t c;

        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sensor_beat = '0;
        s_process_beat = '0;
        s_report_beat = '0;
        s_now_tick = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        tick_now = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // first check after reset sees zero history
        push_check({32'h0, 32'h0, 32'h0, 32'h0});
        push_check({32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF});
        push_check({32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0});
        push_check({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000});
        push_check({32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h7FFF_FFFF});
        push_check({32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0, 32'h5555_AAAA});
        settle();
        write_reg_port(REG_SPARE, $urandom);
        write_reg_port(REG_TOP, '1);

        // hold the block healthy across several limits
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            case (ph % 5)
                0: lim = 8'd1;
                1: lim = 8'd255;
                2: lim = 8'd2;
                default: lim = limit_t'($urandom_range(1, 255));
            endcase
            write_reg_port(hbws_pkg::REG_MISS_LIMIT, limit_word(lim));
            if (ph % 3 == 0)
                write_reg_port(hbws_pkg::REG_GRACE_TICKS, $urandom);
            calm = ($urandom_range(0, 3) == 0);
            hold = (ph % 2 == 1) ? 15 : $urandom_range(1, 8);
            for (int n = 0; n < 120; n++) begin
                c.sensor = pick_beat(0, hold, 1'b1);
                c.process = pick_beat(1, hold, 1'b1);
                c.report = pick_beat(2, hold, 1'b1);
                c.tick = advance_tick();
                push_check(c);
            end
        end

        // latch the fault, or with a miss limit of zero leave it to the first check below
        settle();
        calm = ($urandom_range(0, 3) == 0);
        write_reg_port(hbws_pkg::REG_GRACE_TICKS, pick_grace());
        tick_now = 32'hFFFF_FFFF - $urandom_range(0, 50);
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            write_reg_port(hbws_pkg::REG_MISS_LIMIT, limit_word(8'd0));
        end else begin
            write_reg_port(hbws_pkg::REG_MISS_LIMIT,
                           limit_word(limit_t'($urandom_range(1, 6))));
            stuck = LANES'($urandom_range(1, 7));
            c.sensor = board.last_seen[0] + 32'd1;
            c.process = board.last_seen[1] + 32'd1;
            c.report = board.last_seen[2] + 32'd1;
            c.tick = tick_now;
            push_check(c);
            while (!board.latched) begin
                c.sensor = stuck[2] ? board.last_seen[0] : board.last_seen[0] + 32'd1;
                c.process = stuck[1] ? board.last_seen[1] : board.last_seen[1] + 32'd1;
                c.report = stuck[0] ? board.last_seen[2] : board.last_seen[2] + 32'd1;
                c.tick = tick_now + $urandom_range(0, 3);
                tick_now = c.tick;
                push_check(c);
            end
        end

        // run on with the fault latched and sweep the grace period
        for (int sub = 0; sub < 5; sub++) begin
            if (sub != 0) begin
                settle();
                write_reg_port(hbws_pkg::REG_GRACE_TICKS, pick_grace());
                if (sub == 2)
                    write_reg_port(hbws_pkg::REG_MISS_LIMIT,
                                   limit_word(limit_t'($urandom_range(1, 255))));
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 90; n++) begin
                c.sensor = pick_beat(0, 8, 1'b0);
                c.process = pick_beat(1, 8, 1'b0);
                c.report = pick_beat(2, 8, 1'b0);
                c.tick = tick_after_fault();
                push_check(c);
            end
        end

        settle();
        repeat (10) @(negedge aclk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = pause_len();
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.compare_verdict(m_feed, m_fault, m_fault_cause);
            @(negedge aclk);
        end
    end

endmodule
